### design/ejo_pkg.sv
// Package for the Exif orientation parser: parse phases, queue item type,
// byte-order join and rotation lookup. No dependencies.
`timescale 1ns / 1ps
package ejo_pkg;
	localparam int HDR_BYTES = 8;
	localparam int Q_DEPTH = 4;
	localparam logic [7:0] MK_FF = 8'hFF;
	localparam logic [7:0] MK_SOI = 8'hD8;
	localparam logic [7:0] MK_SOS = 8'hDA;
	localparam logic [7:0] MK_APP1 = 8'hE1;
	localparam logic [7:0] MK_TEM = 8'h01;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_EOI = 8'hD9;
	localparam logic [15:0] TIFF_MAGIC = 16'h002A;
	localparam logic [15:0] TAG_ORIENT = 16'h0112;
	localparam logic [15:0] TYPE_SHORT = 16'h0003;
	localparam logic [15:0] ENTRY_BYTES = 16'd12;
	localparam logic [7:0] ORD_II = 8'h49;
	localparam logic [7:0] ORD_MM = 8'h4D;

	typedef enum logic [3:0] {
		PH_SOI0, PH_SOI1, PH_MARK_FF, PH_MARK_CODE, PH_LEN_HI, PH_LEN_LO,
		PH_EXIF_ID, PH_SKIP, PH_TIFF_HDR, PH_IFD_SKIP, PH_CNT0, PH_CNT1,
		PH_ENTRY, PH_ENTRY_MATCH, PH_ENTRY_OTHER, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_ff;
		logic       is_standalone;
		logic       is_sos;
	} item_t;

	function automatic logic [15:0] join16(input logic big, input logic [7:0] first,
		input logic [7:0] second);
		return big ? {first, second} : {second, first};
	endfunction

	function automatic logic [7:0] exif_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h45;
			3'd1: c = 8'h78;
			3'd2: c = 8'h69;
			3'd3: c = 8'h66;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] turns_of(input logic [3:0] o);
		logic [1:0] t;
		unique case (o)
			4'd3, 4'd4: t = 2'd2;
			4'd5, 4'd8: t = 2'd3;
			4'd6, 4'd7: t = 2'd1;
			default: t = 2'd0;
		endcase
		return t;
	endfunction
endpackage

### design/ejo_if.sv
// Valid/ready channel interfaces for file bytes and orientation results.
// Depends on nothing.
`timescale 1ns / 1ps
interface ejo_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface ejo_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] orientation;
	logic [1:0] quarter_turns;
	modport source(output valid, orientation, quarter_turns, input ready);
	modport sink(input valid, orientation, quarter_turns, output ready);
endinterface

### design/ejo_front.sv
// Front end: accept file bytes and tag them with marker classes.
// Depends on ejo_pkg and ejo_if.
`timescale 1ns / 1ps
module ejo_front import ejo_pkg::*; (
	ejo_byte_if.sink byte_ch,
	input  logic     q_full,
	output logic     push,
	output item_t    push_item
);
	assign byte_ch.ready = !q_full;
	assign push = byte_ch.valid && !q_full;
	always_comb begin
		push_item.data = byte_ch.data_byte;
		push_item.last = byte_ch.last_byte;
		push_item.is_ff = (byte_ch.data_byte == MK_FF);
		push_item.is_standalone = (byte_ch.data_byte == MK_TEM) ||
			((byte_ch.data_byte >= MK_RST0) && (byte_ch.data_byte <= MK_EOI));
		push_item.is_sos = (byte_ch.data_byte == MK_SOS);
	end
endmodule

### design/ejo_queue.sv
// Short queue between classifier and parser.
// Depends on ejo_pkg.
`timescale 1ns / 1ps
module ejo_queue import ejo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head
);
	localparam int AW = $clog2(Q_DEPTH);
	item_t mem_q [Q_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

### design/ejo_back.sv
// Back end: marker walk, Exif/TIFF header and IFD0 scan, result register.
// Depends on ejo_pkg and ejo_if.
`timescale 1ns / 1ps
module ejo_back import ejo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] default_orientation,
	input  logic       q_valid,
	input  item_t      q_head,
	output logic       pop,
	ejo_result_if.source result_ch
);
	phase_t phase_q, phase_n;
	logic [15:0] seg_pos_q, seg_pos_n, seg_len_q, seg_len_n;
	logic [15:0] tpos_q, tpos_n, tlim_q, tlim_n;
	logic [15:0] ent_q, ent_n, fa_q, fa_n;
	logic [31:0] off_q, off_n;
	logic big_q, big_n, ans_q, ans_n, replay_q, replay_n;
	logic [7:0] hdr_q [HDR_BYTES];
	logic hdr_we;
	logic out_valid_q, out_valid_n;
	logic [3:0] out_o_q, out_o_n;
	logic step, out_ok, dec;
	logic [3:0] dec_val;
	logic [7:0] b;

	assign out_ok = !out_valid_q || result_ch.ready;
	assign step = out_ok && (replay_q || q_valid);
	assign pop = step && !replay_q;
	assign b = replay_q ? hdr_q[tpos_q[2:0]] : q_head.data;

	always_comb begin
		logic [15:0] len_v, j_v, ent_v, tp1;
		logic [31:0] off_v;
		phase_n = phase_q; seg_pos_n = seg_pos_q; seg_len_n = seg_len_q;
		tpos_n = tpos_q; tlim_n = tlim_q; ent_n = ent_q; fa_n = fa_q;
		off_n = off_q; big_n = big_q; ans_n = ans_q; replay_n = replay_q;
		hdr_we = 1'b0; dec = 1'b0; dec_val = default_orientation;
		len_v = {seg_len_q[15:8], b};
		j_v = join16(big_q, fa_q[7:0], b);
		tp1 = tpos_q + 16'd1;
		ent_v = '0;
		off_v = big_q ? {hdr_q[4], hdr_q[5], hdr_q[6], b} : {b, hdr_q[6], hdr_q[5], hdr_q[4]};
		if (step && !ans_q) begin
			unique case (phase_q)
				PH_SOI0: if (q_head.is_ff) phase_n = PH_SOI1; else dec = 1'b1;
				PH_SOI1: if (b == MK_SOI) phase_n = PH_MARK_FF; else dec = 1'b1;
				PH_MARK_FF: if (q_head.is_ff) phase_n = PH_MARK_CODE; else dec = 1'b1;
				PH_MARK_CODE: begin
					fa_n = {8'd0, b};
					if (q_head.is_standalone) phase_n = PH_MARK_FF;
					else if (q_head.is_sos) dec = 1'b1;
					else phase_n = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					seg_len_n = {b, 8'd0};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (len_v < 16'd2) dec = 1'b1;
					else begin
						seg_len_n = len_v - 16'd2;
						seg_pos_n = '0;
						if (fa_q == {8'd0, MK_APP1} && len_v >= 16'd8) phase_n = PH_EXIF_ID;
						else if (len_v == 16'd2) phase_n = PH_MARK_FF;
						else phase_n = PH_SKIP;
					end
				end
				PH_EXIF_ID: begin
					seg_pos_n = seg_pos_q + 16'd1;
					if (b != exif_char(seg_pos_q[2:0])) begin
						phase_n = (seg_pos_n >= seg_len_q) ? PH_MARK_FF : PH_SKIP;
					end else if (seg_pos_n >= 16'd6) begin
						tlim_n = seg_len_q - 16'd6;
						tpos_n = '0;
						if (tlim_n < 16'(HDR_BYTES)) dec = 1'b1;
						else phase_n = PH_TIFF_HDR;
					end
				end
				PH_SKIP: begin
					seg_pos_n = seg_pos_q + 16'd1;
					if (seg_pos_n >= seg_len_q) phase_n = PH_MARK_FF;
				end
				PH_TIFF_HDR: begin
					if (tpos_q >= 16'(HDR_BYTES)) dec = 1'b1;
					else begin
						hdr_we = 1'b1;
						tpos_n = tp1;
						if (tpos_q == 16'd1) begin
							if (hdr_q[0] == ORD_II && b == ORD_II) big_n = 1'b0;
							else if (hdr_q[0] == ORD_MM && b == ORD_MM) big_n = 1'b1;
							else dec = 1'b1;
						end else if (tpos_q == 16'd3) begin
							if (join16(big_q, hdr_q[2], b) != TIFF_MAGIC) dec = 1'b1;
						end else if (tpos_q == 16'(HDR_BYTES - 1)) begin
							off_n = off_v;
							if ({1'b0, off_v} + 33'd2 > {17'd0, tlim_q}) dec = 1'b1;
							else if (off_v < 32'(HDR_BYTES)) begin
								phase_n = PH_CNT0;
								tpos_n = off_v[15:0];
								replay_n = 1'b1;
							end else if (off_v == 32'(HDR_BYTES)) phase_n = PH_CNT0;
							else phase_n = PH_IFD_SKIP;
						end
					end
				end
				PH_IFD_SKIP: begin
					tpos_n = tp1;
					if ({16'd0, tp1} >= off_q) phase_n = PH_CNT0;
				end
				PH_CNT0: begin
					tpos_n = tp1;
					fa_n = {8'd0, b};
					phase_n = PH_CNT1;
				end
				PH_CNT1, PH_ENTRY_OTHER: begin
					tpos_n = tp1;
					if (phase_q == PH_CNT1) ent_v = j_v;
					else begin
						seg_pos_n = seg_pos_q + 16'd1;
						ent_v = ent_q - 16'd1;
					end
					if (phase_q == PH_CNT1 || seg_pos_q >= 16'd11) begin
						ent_n = ent_v;
						if (ent_v == '0 || ({1'b0, tp1} + {1'b0, ENTRY_BYTES} > {1'b0, tlim_q}))
							dec = 1'b1;
						else begin
							seg_pos_n = '0;
							phase_n = PH_ENTRY;
						end
					end
				end
				PH_ENTRY: begin
					tpos_n = tp1;
					seg_pos_n = seg_pos_q + 16'd1;
					if (seg_pos_q == '0) fa_n = {8'd0, b};
					else phase_n = (j_v == TAG_ORIENT) ? PH_ENTRY_MATCH : PH_ENTRY_OTHER;
				end
				PH_ENTRY_MATCH: begin
					tpos_n = tp1;
					seg_pos_n = seg_pos_q + 16'd1;
					if (seg_pos_q == 16'd2 || seg_pos_q == 16'd8) fa_n = {8'd0, b};
					else if (seg_pos_q == 16'd3) begin
						if (j_v != TYPE_SHORT) dec = 1'b1;
					end else if (seg_pos_q == 16'd9) fa_n = j_v;
					else if (seg_pos_q >= 16'd11) begin
						dec = 1'b1;
						if (fa_q >= 16'd1 && fa_q <= 16'd8) dec_val = fa_q[3:0];
					end
				end
				PH_DONE: ;
				default: ;
			endcase
			if (dec) begin
				phase_n = PH_DONE;
				ans_n = 1'b1;
			end
		end
		if (step && replay_q)
			replay_n = (tpos_n < 16'(HDR_BYTES)) && !ans_n;
		if (step && !replay_q && q_head.last) begin
			if (!ans_n) dec = 1'b1;
			phase_n = PH_SOI0; seg_pos_n = '0; seg_len_n = '0; tpos_n = '0;
			tlim_n = '0; big_n = 1'b0; off_n = '0; ent_n = '0; fa_n = '0;
			ans_n = 1'b0; replay_n = 1'b0;
		end
		out_valid_n = out_valid_q && !result_ch.ready;
		out_o_n = out_o_q;
		if (step && dec) begin
			out_valid_n = 1'b1;
			out_o_n = dec_val;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) hdr_q[tpos_q[2:0]] <= b;
		out_o_q <= out_o_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOI0; seg_pos_q <= '0; seg_len_q <= '0; tpos_q <= '0;
			tlim_q <= '0; big_q <= 1'b0; off_q <= '0; ent_q <= '0; fa_q <= '0;
			ans_q <= 1'b0; replay_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n; seg_pos_q <= seg_pos_n; seg_len_q <= seg_len_n;
			tpos_q <= tpos_n; tlim_q <= tlim_n; big_q <= big_n; off_q <= off_n;
			ent_q <= ent_n; fa_q <= fa_n; ans_q <= ans_n; replay_q <= replay_n;
			out_valid_q <= out_valid_n;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.orientation = out_o_q;
	assign result_ch.quarter_turns = turns_of(out_o_q);

`ifndef SYNTH
	a_replay_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		replay_q |-> (tpos_q < 16'(HDR_BYTES)))
		else $error("replay past header buffer");
	a_done_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> ans_q)
		else $error("done without answer");
	a_replay_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		replay_q |-> !pop)
		else $error("queue popped during replay");
`endif
endmodule

### design/jpeg_exif_orientation_parser.sv
// Top level of the JPEG Exif orientation parser: config register, front end,
// queue and back end. Depends on ejo_pkg, ejo_if, ejo_front, ejo_queue, ejo_back.
//
// channel    dir  payload                        handshake
// byte_ch    in   data_byte[7:0], last_byte      valid/ready
// result_ch  out  orientation[3:0], quarter_turns[1:0]  valid/ready
// cfg        in   cfg_wdata[3:0] (default_orientation)  cfg_we, no ready
//
// One byte per cycle sustained but for the stalls below: the parser consumes one
// queued request per cycle. When the IFD0 offset points inside the first 8 TIFF
// bytes, the parser replays the buffered bytes from that offset, one per cycle, and
// holds the queue meanwhile. Reset clears all control state; default_orientation goes
// to 1. A stalled result holds in the output register; the parser stalls whenever that
// register holds a result not yet taken, and the 4-entry queue absorbs input meanwhile.
`timescale 1ns / 1ps
module jpeg_exif_orientation_parser import ejo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	ejo_byte_if.sink   byte_ch,
	ejo_result_if.source result_ch
);
	logic [3:0] default_q;
	logic push, q_full, q_valid, pop;
	item_t push_item, q_head;

	// Hold the default orientation; user rule, not enforced: written only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) default_q <= 4'd1;
		else if (cfg_we) default_q <= cfg_wdata;
	end

	// Classify each accepted byte and push it into the queue.
	ejo_front u_front (
		.byte_ch(byte_ch), .q_full(q_full), .push(push), .push_item(push_item)
	);

	ejo_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.full(q_full), .pop(pop), .valid(q_valid), .head(q_head)
	);

	// Advance the parse one request per cycle unless stalled; drive the result register.
	ejo_back u_back (
		.clk(clk), .arst_n(arst_n), .default_orientation(default_q),
		.q_valid(q_valid), .q_head(q_head), .pop(pop), .result_ch(result_ch)
	);
endmodule

### tb/ejo_checker.sv
// Scoreboard for the Exif orientation parser: watches the byte, result and
// register ports, predicts one orientation per file and compares it.
// Depends on ejo_pkg and the channel interfaces in ejo_if.
`timescale 1ns / 1ps
module ejo_checker import ejo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	ejo_byte_if        byte_ch,
	ejo_result_if      result_ch,
	output int         fail_count,
	output int         outstanding
);
	typedef struct {
		logic [3:0] orientation;
		logic [1:0] turns;
	} rotation_t;

	rotation_t  rotation_q[$];
	logic [3:0] dflt;
	phase_t     ph;
	logic [15:0] spos, slen, tpos, tlim, left, fa;
	logic       big_order, decided, got;
	logic [7:0] hdr[HDR_BYTES];
	logic [31:0] ifdo;
	logic [3:0] got_code;
	logic [7:0] exif_sig[6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

	function automatic logic [1:0] quarter_of(logic [3:0] o);
		case (o)
			4'd3, 4'd4: return 2'd2;
			4'd5, 4'd8: return 2'd3;
			4'd6, 4'd7: return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [15:0] pair(logic [7:0] a, logic [7:0] b);
		return big_order ? {a, b} : {b, a};
	endfunction

	function automatic void clear_parse();
		ph = PH_SOI0;
		spos = 0; slen = 0; tpos = 0; tlim = 0; left = 0; fa = 0;
		big_order = 0; ifdo = 0; decided = 0;
		foreach (hdr[i]) hdr[i] = 0;
	endfunction

	function automatic void decide(logic [3:0] v);
		got = 1;
		got_code = v;
		decided = 1;
		ph = PH_DONE;
	endfunction

	function automatic void start_entry();
		if (left == 0 || 32'(tpos) + 12 > 32'(tlim)) begin
			decide(dflt);
		end else begin
			spos = 0;
			ph = PH_ENTRY;
		end
	endfunction

	function automatic void ifd_byte(logic [7:0] b);
		logic [15:0] idx;
		idx = spos;
		tpos = tpos + 1;
		case (ph)
			PH_IFD_SKIP: if (32'(tpos) >= ifdo) ph = PH_CNT0;
			PH_CNT0: begin
				fa = {8'h00, b};
				ph = PH_CNT1;
			end
			PH_CNT1: begin
				left = pair(fa[7:0], b);
				start_entry();
			end
			PH_ENTRY: begin
				spos = idx + 1;
				if (idx == 0) fa = {8'h00, b};
				else ph = (pair(fa[7:0], b) == TAG_ORIENT) ? PH_ENTRY_MATCH : PH_ENTRY_OTHER;
			end
			PH_ENTRY_MATCH: begin
				spos = idx + 1;
				if (idx == 2 || idx == 8) begin
					fa = {8'h00, b};
				end else if (idx == 3) begin
					if (pair(fa[7:0], b) != TYPE_SHORT) decide(dflt);
				end else if (idx == 9) begin
					fa = pair(fa[7:0], b);
				end else if (idx >= 11) begin
					if (fa >= 1 && fa <= 8) decide(fa[3:0]);
					else decide(dflt);
				end
			end
			PH_ENTRY_OTHER: begin
				spos = idx + 1;
				if (idx >= 11) begin
					left = left - 1;
					start_entry();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void header_byte(logic [7:0] b);
		logic [15:0] pos;
		pos = tpos;
		if (pos >= HDR_BYTES) begin
			decide(dflt);
			return;
		end
		hdr[pos[2:0]] = b;
		tpos = pos + 1;
		if (pos == 1) begin
			if (hdr[0] == ORD_II && b == ORD_II) big_order = 0;
			else if (hdr[0] == ORD_MM && b == ORD_MM) big_order = 1;
			else decide(dflt);
		end else if (pos == 3) begin
			if (pair(hdr[2], b) != TIFF_MAGIC) decide(dflt);
		end else if (pos == HDR_BYTES - 1) begin
			ifdo = big_order ? {hdr[4], hdr[5], hdr[6], hdr[7]}
				: {hdr[7], hdr[6], hdr[5], hdr[4]};
			if (64'(ifdo) + 2 > 64'(tlim)) begin
				decide(dflt);
			end else if (ifdo < HDR_BYTES) begin
				// replay the buffered header from the IFD0 offset
				ph = PH_CNT0;
				tpos = ifdo[15:0];
				while (tpos < HDR_BYTES && !decided) ifd_byte(hdr[tpos[2:0]]);
			end else if (ifdo == HDR_BYTES) begin
				ph = PH_CNT0;
			end else begin
				ph = PH_IFD_SKIP;
			end
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		case (ph)
			PH_SOI0: if (b == MK_FF) ph = PH_SOI1; else decide(dflt);
			PH_SOI1: if (b == MK_SOI) ph = PH_MARK_FF; else decide(dflt);
			PH_MARK_FF: if (b == MK_FF) ph = PH_MARK_CODE; else decide(dflt);
			PH_MARK_CODE: begin
				fa = {8'h00, b};
				if (b == MK_TEM || (b >= MK_RST0 && b <= MK_EOI)) ph = PH_MARK_FF;
				else if (b == MK_SOS) decide(dflt);
				else ph = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				slen = {b, 8'h00};
				ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				slen = slen | b;
				if (slen < 2) begin
					decide(dflt);
				end else begin
					slen = slen - 2;
					spos = 0;
					if (fa == {8'h00, MK_APP1} && slen >= 6) ph = PH_EXIF_ID;
					else if (slen == 0) ph = PH_MARK_FF;
					else ph = PH_SKIP;
				end
			end
			PH_EXIF_ID: begin
				if (b != exif_sig[spos % 6]) begin
					spos = spos + 1;
					ph = (spos >= slen) ? PH_MARK_FF : PH_SKIP;
				end else begin
					spos = spos + 1;
					if (spos >= 6) begin
						tlim = slen - 6;
						tpos = 0;
						if (tlim < HDR_BYTES) decide(dflt);
						else ph = PH_TIFF_HDR;
					end
				end
			end
			PH_SKIP: begin
				spos = spos + 1;
				if (spos >= slen) ph = PH_MARK_FF;
			end
			PH_TIFF_HDR: header_byte(b);
			PH_DONE: ;
			default: ifd_byte(b);
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic last);
		got = 0;
		if (!decided) parse_byte(b);
		if (last) begin
			if (!decided) decide(dflt);
			clear_parse();
		end
		if (got) rotation_q.push_back('{got_code, quarter_of(got_code)});
	endfunction

	assign outstanding = rotation_q.size();

	always @(posedge clk or negedge arst_n) begin
		rotation_t want;
		if (!arst_n) begin
			dflt = 4'd1;
			fail_count = 0;
			rotation_q.delete();
			clear_parse();
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (rotation_q.size() == 0) begin
					$error("orientation result with none expected: %0d", result_ch.orientation);
					fail_count++;
				end else begin
					want = rotation_q.pop_front();
					if (result_ch.orientation !== want.orientation) begin
						$error("orientation: expected %0d, got %0d", want.orientation,
							result_ch.orientation);
						fail_count++;
					end
					if (result_ch.quarter_turns !== want.turns) begin
						$error("quarter_turns: expected %0d, got %0d", want.turns,
							result_ch.quarter_turns);
						fail_count++;
					end
				end
			end
			if (byte_ch.valid && byte_ch.ready)
				predict_byte(byte_ch.data_byte, byte_ch.last_byte);
			if (cfg_we) dflt = cfg_wdata;
		end
	end
endmodule

### tb/tb_top.sv
// Top of the orientation parser bench: clock, reset, file generation, flow
// control and verdict. Depends on ejo_pkg, ejo_if, the parser and ejo_checker.
`timescale 1ns / 1ps
module tb_top import ejo_pkg::*;;
	localparam int IDLE_LIMIT = 4000;   // cycles without any handshake
	localparam int SETTLE = 24;         // queue depth plus header replay, with margin
	localparam int BYTES_PER_PHASE = 200;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	int         fail_count;
	int         outstanding;
	int         tx_idle;
	int         rx_idle;
	int         bytes_sent;
	int         quiet;

	ejo_byte_if   byte_ch();
	ejo_result_if result_ch();

	jpeg_exif_orientation_parser dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.byte_ch(byte_ch), .result_ch(result_ch)
	);

	ejo_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.byte_ch(byte_ch), .result_ch(result_ch),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Throttle the result side; ready changes only at the falling edge.
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= rx_idle);
	end

	// Abort when the channels stop moving for too long.
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic void put16(ref logic [7:0] q[$], input bit big, input logic [15:0] v);
		if (big) begin
			q.push_back(v[15:8]); q.push_back(v[7:0]);
		end else begin
			q.push_back(v[7:0]); q.push_back(v[15:8]);
		end
	endfunction

	function automatic void put32(ref logic [7:0] q[$], input bit big, input logic [31:0] v);
		if (big) begin
			put16(q, big, v[31:16]); put16(q, big, v[15:0]);
		end else begin
			put16(q, big, v[15:0]); put16(q, big, v[31:16]);
		end
	endfunction

	// Append an Exif APP1 segment whose IFD0 holds nent entries when ifdo >= HDR_BYTES; the
	// Orientation entry sits at slot opos (absent when opos >= nent).
	function automatic void add_exif(ref logic [7:0] f[$], input bit big, input int ov,
		input int typ, input int ifdo, input int nent, input int opos, input int extra);
		logic [7:0]  t[$];
		logic [15:0] tag;
		int          seg_len;
		put16(t, big, big ? {ORD_MM, ORD_MM} : {ORD_II, ORD_II});
		put16(t, big, TIFF_MAGIC);
		put32(t, big, ifdo);
		while (t.size() < ifdo) t.push_back($urandom_range(255));
		if (ifdo >= HDR_BYTES) put16(t, big, nent);
		for (int i = 0; i < nent; i++) begin
			if (i == opos) begin
				put16(t, big, TAG_ORIENT);
				put16(t, big, typ);
				put32(t, big, 1);
				put16(t, big, ov);
				put16(t, big, 0);
			end else begin
				tag = $urandom_range(16'hFFFF);
				if (tag == TAG_ORIENT) tag ^= 16'h0001;
				put16(t, big, tag);
				put16(t, big, $urandom_range(16'hFFFF));
				put32(t, big, $urandom);
				put32(t, big, $urandom);
			end
		end
		repeat (extra) t.push_back($urandom_range(255));
		seg_len = t.size() + 8;
		f.push_back(MK_FF); f.push_back(MK_APP1);
		f.push_back(seg_len[15:8]); f.push_back(seg_len[7:0]);
		f.push_back(8'h45); f.push_back(8'h78); f.push_back(8'h69); f.push_back(8'h66);
		f.push_back(8'h00); f.push_back(8'h00);
		foreach (t[i]) f.push_back(t[i]);
	endfunction

	// Mostly well-formed files with random content; the rest noise or damaged.
	function automatic void random_file(ref logic [7:0] f[$]);
		int n, nent, ifdo, ov, typ, cut;
		f = {MK_FF, MK_SOI};
		if ($urandom_range(99) < 10) begin
			if ($urandom_range(1)) f.delete();
			repeat ($urandom_range(1, 12)) f.push_back($urandom_range(255));
			return;
		end
		repeat ($urandom_range(2)) begin
			case ($urandom_range(2))
				0: begin
					f.push_back(MK_FF);
					f.push_back($urandom_range(1) ? MK_TEM : MK_RST0 + $urandom_range(9));
				end
				1: begin
					n = $urandom_range(6);
					f.push_back(MK_FF); f.push_back(8'hE0);
					f.push_back(8'h00); f.push_back(n + 2);
					repeat (n) f.push_back($urandom_range(255));
				end
				default: begin
					f.push_back(MK_FF); f.push_back(MK_APP1);
					f.push_back(8'h00); f.push_back(8'd10);
					f.push_back(8'h45); f.push_back(8'h78);
					repeat (6) f.push_back($urandom_range(255));
				end
			endcase
		end
		ov = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(15);
		typ = ($urandom_range(99) < 85) ? TYPE_SHORT : $urandom_range(16'hFFFF);
		case ($urandom_range(4))
			0: ifdo = $urandom_range(HDR_BYTES - 1);
			1: ifdo = HDR_BYTES + $urandom_range(1, 4);
			default: ifdo = HDR_BYTES;
		endcase
		nent = $urandom_range(4);
		add_exif(f, $urandom_range(1), ov, typ, ifdo, nent, $urandom_range(nent),
			$urandom_range(3));
		f.push_back(MK_FF); f.push_back(MK_SOS);
		f.push_back($urandom_range(255)); f.push_back($urandom_range(255));
		if ($urandom_range(99) < 15) f[$urandom_range(f.size() - 1)] = $urandom_range(255);
		if ($urandom_range(99) < 10) begin
			cut = $urandom_range(f.size() - 1);
			f = f[0:cut];
		end
	endfunction

	task automatic send_file(input logic [7:0] f[$]);
		foreach (f[i]) begin
			while ($urandom_range(99) < tx_idle) begin
				byte_ch.valid <= 1'b0;
				@(negedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.data_byte <= f[i];
			byte_ch.last_byte <= (i == f.size() - 1);
			do @(posedge clk); while (!byte_ch.ready);
			@(negedge clk);
			bytes_sent++;
		end
	endtask

	// Drain the parser, then write the default orientation register.
	task automatic set_default(input logic [3:0] v);
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] f[$];
		logic [3:0] defaults[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		bytes_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed files: every orientation, big-endian for odd values and little-endian
		// for even, then the usual ways to fall back to the default.
		set_default(4'd8);
		send_file('{MK_FF});
		for (int ov = 1; ov <= 8; ov++) begin
			f = {MK_FF, MK_SOI};
			add_exif(f, ov[0], ov, TYPE_SHORT, HDR_BYTES, 2, 1, 0);
			send_file(f);
		end
		f = {MK_FF, MK_SOI};
		add_exif(f, 1'b0, 6, TYPE_SHORT, 0, 0, 0, 24);   // IFD0 inside the header
		send_file(f);
		f = {MK_FF, MK_SOI};
		add_exif(f, 1'b1, 3, 16'h0004, HDR_BYTES, 1, 0, 0);   // wrong tag type
		send_file(f);
		f = {MK_FF, MK_SOI};
		add_exif(f, 1'b0, 9, TYPE_SHORT, HDR_BYTES, 1, 0, 0);   // value out of range
		send_file(f);
		send_file('{MK_FF, MK_SOI, MK_FF, MK_SOS, 8'h00});   // SOS before any Exif
		send_file('{MK_FF, MK_SOI, MK_FF, 8'hE0, 8'h00, 8'h01, 8'hFF});   // length below 2
		send_file('{MK_FF, MK_SOI, MK_FF, MK_TEM, MK_FF, MK_EOI, 8'h12, 8'h34});

		defaults = '{4'd1, 4'd15, 4'd0, 4'd8, 4'($urandom), 4'd5};
		for (int p = 0; p < 3; p++) begin
			tx_idle = (p == 0) ? 21 : (p == 1) ? 59 : 0;
			rx_idle = (p == 0) ? 59 : (p == 1) ? 21 : 0;
			for (int s = 0; s < 2; s++) begin
				set_default(defaults[2 * p + s]);
				bytes_sent = 0;
				while (bytes_sent < BYTES_PER_PHASE) begin
					random_file(f);
					send_file(f);
				end
			end
		end

		byte_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

### sim.f
design/ejo_pkg.sv
design/ejo_if.sv
design/ejo_front.sv
design/ejo_queue.sv
design/ejo_back.sv
design/jpeg_exif_orientation_parser.sv
tb/ejo_checker.sv
tb/tb_top.sv
